[hw/rtl/tsu_pkg.sv]
// Shared types, constants and decode functions for the TOML string unescaper.
// Used by the front parser, the request queue, the result sequencer and the top level.
// No dependencies.
`timescale 1ns / 1ps

package tsu_pkg;

    // Characters the parser cares about
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_BSL   = 8'h5c;

    // Code point limits
    localparam logic [31:0] CP_MAX  = 32'h0010_ffff;
    localparam logic [31:0] SURR_LO = 32'h0000_d800;
    localparam logic [31:0] SURR_HI = 32'h0000_dfff;
    localparam logic [20:0] CP_1B   = 21'h00_007f;
    localparam logic [20:0] CP_2B   = 21'h00_07ff;
    localparam logic [20:0] CP_3B   = 21'h00_ffff;

    // UTF-8 lead and continuation bytes
    localparam logic [7:0] UTF8_LEAD2 = 8'hc0;
    localparam logic [7:0] UTF8_LEAD3 = 8'he0;
    localparam logic [7:0] UTF8_LEAD4 = 8'hf0;
    localparam logic [7:0] UTF8_CONT  = 8'h80;
    localparam logic [7:0] UTF8_MASK  = 8'h3f;

    // Digits left for the short and long unicode escapes
    localparam logic [3:0] HEX_SHORT = 4'd4;
    localparam logic [3:0] HEX_LONG  = 4'd8;

    // Request queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_BODY = 2'd1,
        MODE_ESC  = 2'd2,
        MODE_HEX  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_NO_QUOTE  = 3'd1,
        ERR_BAD_ESC   = 3'd2,
        ERR_BAD_HEX   = 3'd3,
        ERR_BAD_CP    = 3'd4,
        ERR_UNTERM    = 3'd5
    } err_t;

    typedef enum logic [1:0] {
        ESC_SIMPLE = 2'd0,
        ESC_U4     = 2'd1,
        ESC_U8     = 2'd2,
        ESC_BAD    = 2'd3
    } esc_kind_t;

    // One request from the parser: a run of 1 to 4 bytes, a done or a reject
    typedef struct packed {
        kind_t            kind;
        logic [1:0]       last_idx;
        logic [3:0][7:0]  data;
        err_t             err;
        logic [15:0]      count;
    } req_t;

    // Queue status seen by the parser and the sequencer
    typedef struct packed {
        logic full;
        logic head_valid;
    } qstat_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    typedef struct packed {
        esc_kind_t  kind;
        logic [7:0] chr;
    } esc_t;

    typedef struct packed {
        logic [1:0]      last_idx;
        logic [3:0][7:0] data;
    } utf8_t;

    // Decode one hex digit, either case
    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t r;
        r.ok  = 1'b1;
        r.val = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r.val = 4'(c - 8'h30);
        end
        else if (c inside {[8'h61:8'h66]}) begin
            r.val = 4'(c - 8'h57);
        end
        else if (c inside {[8'h41:8'h46]}) begin
            r.val = 4'(c - 8'h37);
        end
        else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    // Map the character after a backslash
    function automatic esc_t esc_decode(input logic [7:0] c);
        esc_t r;
        r.kind = ESC_SIMPLE;
        r.chr  = 8'h00;
        case (c)
            8'h22:   r.chr = 8'h22;
            8'h5c:   r.chr = 8'h5c;
            8'h62:   r.chr = 8'h08;
            8'h74:   r.chr = 8'h09;
            8'h6e:   r.chr = 8'h0a;
            8'h66:   r.chr = 8'h0c;
            8'h72:   r.chr = 8'h0d;
            8'h75:   r.kind = ESC_U4;
            8'h55:   r.kind = ESC_U8;
            default: r.kind = ESC_BAD;
        endcase
        return r;
    endfunction

    // Encode a valid code point as 1 to 4 UTF-8 bytes, first byte in slot 0
    function automatic utf8_t utf8_encode(input logic [20:0] cp);
        utf8_t r;
        r.data = '0;
        if (cp <= CP_1B) begin
            r.last_idx = 2'd0;
            r.data[0]  = cp[7:0];
        end
        else if (cp <= CP_2B) begin
            r.last_idx = 2'd1;
            r.data[0]  = UTF8_LEAD2 | {3'b000, cp[10:6]};
            r.data[1]  = UTF8_CONT | ({2'b00, cp[5:0]} & UTF8_MASK);
        end
        else if (cp <= CP_3B) begin
            r.last_idx = 2'd2;
            r.data[0]  = UTF8_LEAD3 | {4'b0000, cp[15:12]};
            r.data[1]  = UTF8_CONT | ({2'b00, cp[11:6]} & UTF8_MASK);
            r.data[2]  = UTF8_CONT | ({2'b00, cp[5:0]} & UTF8_MASK);
        end
        else begin
            r.last_idx = 2'd3;
            r.data[0]  = UTF8_LEAD4 | {5'b00000, cp[20:18]};
            r.data[1]  = UTF8_CONT | ({2'b00, cp[17:12]} & UTF8_MASK);
            r.data[2]  = UTF8_CONT | ({2'b00, cp[11:6]} & UTF8_MASK);
            r.data[3]  = UTF8_CONT | ({2'b00, cp[5:0]} & UTF8_MASK);
        end
        return r;
    endfunction

endpackage

[hw/rtl/tsu_front.sv]
// Front parser: accepts raw bytes, tracks the string state and issues one request
// per byte that has results. Depends on tsu_pkg.
`timescale 1ns / 1ps

module tsu_front
    import tsu_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       first_byte,
    input  logic       end_of_text,
    input  qstat_t     qstat,
    output logic       push,
    output req_t       req
);

    mode_t                  mode_reg, mode_next, mode_step;
    logic                   lit_reg, lit_next;
    logic [3:0]             left_reg, left_next;
    logic [31:0]            acc_reg, acc_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;

    logic                   accept;
    logic                   req_valid;
    logic [7:0]             quote_char;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [31:0]            acc_shift;
    logic [3:0]             left_dec;
    logic                   cp_bad;
    logic                   is_quote;
    hex_t                   hex;
    esc_t                   esc;
    utf8_t                  enc;

    assign accept = in_valid && !qstat.full;
    assign push   = accept && req_valid;

    // Decode the incoming byte against the current state
    assign quote_char = lit_reg ? CH_APOS : CH_QUOTE;
    assign is_quote   = (in_byte == CH_QUOTE) || (in_byte == CH_APOS);
    assign count_inc  = (&count_reg) ? count_reg : count_reg + COUNT_WIDTH'(1);
    assign hex        = hex_decode(in_byte);
    assign esc        = esc_decode(in_byte);
    assign acc_shift  = {acc_reg[27:0], hex.val};
    assign left_dec   = (left_reg != 4'd0) ? left_reg - 4'd1 : 4'd0;
    assign enc        = utf8_encode(acc_shift[20:0]);

    always_comb
    begin
        cp_bad = (acc_shift > CP_MAX) || (acc_shift inside {[SURR_LO:SURR_HI]});
    end

    // Next state
    always_comb
    begin
        mode_step  = mode_reg;
        lit_next   = lit_reg;
        left_next  = left_reg;
        acc_next   = acc_reg;
        count_next = count_reg;
        if (first_byte) begin
            if (is_quote) begin
                mode_step  = MODE_BODY;
                lit_next   = (in_byte == CH_APOS);
                left_next  = 4'd0;
                acc_next   = '0;
                count_next = COUNT_WIDTH'(1);
            end
            else begin
                mode_step = MODE_IDLE;
            end
        end
        else begin
            case (mode_reg)
                MODE_BODY:
                begin
                    count_next = count_inc;
                    if (in_byte == quote_char) begin
                        mode_step = MODE_IDLE;
                    end
                    else if (!lit_reg && in_byte == CH_BSL) begin
                        mode_step = MODE_ESC;
                    end
                end
                MODE_ESC:
                begin
                    count_next = count_inc;
                    case (esc.kind)
                        ESC_U4:
                        begin
                            mode_step = MODE_HEX;
                            left_next = HEX_SHORT;
                            acc_next  = '0;
                        end
                        ESC_U8:
                        begin
                            mode_step = MODE_HEX;
                            left_next = HEX_LONG;
                            acc_next  = '0;
                        end
                        ESC_BAD:    mode_step = MODE_IDLE;
                        default:    mode_step = MODE_BODY;
                    endcase
                end
                MODE_HEX:
                begin
                    count_next = count_inc;
                    if (!hex.ok) begin
                        mode_step = MODE_IDLE;
                    end
                    else begin
                        acc_next  = acc_shift;
                        left_next = left_dec;
                        if (left_dec == 4'd0) begin
                            mode_step = cp_bad ? MODE_IDLE : MODE_BODY;
                        end
                    end
                end
                default: ;
            endcase
        end
        // Drop a string that is still open at the end of the text
        mode_next = (end_of_text && mode_step != MODE_IDLE) ? MODE_IDLE : mode_step;
    end

    // Request for this byte
    always_comb
    begin
        req_valid     = 1'b0;
        req.kind      = KIND_BYTE;
        req.last_idx  = 2'd0;
        req.data      = '0;
        req.err       = ERR_NONE;
        req.count     = 16'd0;
        if (first_byte) begin
            if (!is_quote) begin
                req_valid = 1'b1;
                req.kind  = KIND_REJECT;
                req.err   = ERR_NO_QUOTE;
            end
        end
        else begin
            case (mode_reg)
                MODE_BODY:
                begin
                    if (in_byte == quote_char) begin
                        req_valid = 1'b1;
                        req.kind  = KIND_DONE;
                        req.count = 16'(count_inc);
                    end
                    else if (lit_reg || in_byte != CH_BSL) begin
                        req_valid   = 1'b1;
                        req.data[0] = in_byte;
                    end
                end
                MODE_ESC:
                begin
                    if (esc.kind == ESC_SIMPLE) begin
                        req_valid   = 1'b1;
                        req.data[0] = esc.chr;
                    end
                    else if (esc.kind == ESC_BAD) begin
                        req_valid = 1'b1;
                        req.kind  = KIND_REJECT;
                        req.err   = ERR_BAD_ESC;
                    end
                end
                MODE_HEX:
                begin
                    if (!hex.ok) begin
                        req_valid = 1'b1;
                        req.kind  = KIND_REJECT;
                        req.err   = ERR_BAD_HEX;
                    end
                    else if (left_dec == 4'd0) begin
                        req_valid = 1'b1;
                        if (cp_bad) begin
                            req.kind = KIND_REJECT;
                            req.err  = ERR_BAD_CP;
                        end
                        else begin
                            req.last_idx = enc.last_idx;
                            req.data     = enc.data;
                        end
                    end
                end
                default: ;
            endcase
        end
        // An open string at the end of the text replaces everything with one reject
        if (end_of_text && mode_step != MODE_IDLE) begin
            req_valid    = 1'b1;
            req.kind     = KIND_REJECT;
            req.last_idx = 2'd0;
            req.data     = '0;
            req.err      = ERR_UNTERM;
            req.count    = 16'd0;
        end
    end

    // Advance the parse state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_IDLE;
            lit_reg   <= 1'b0;
            left_reg  <= 4'd0;
            acc_reg   <= '0;
            count_reg <= '0;
        end
        else if (accept) begin
            mode_reg  <= mode_next;
            lit_reg   <= lit_next;
            left_reg  <= left_next;
            acc_reg   <= acc_next;
            count_reg <= count_next;
        end
    end

endmodule

[hw/rtl/tsu_queue.sv]
// Short request queue between the parser and the result sequencer.
// Depends on tsu_pkg.
`timescale 1ns / 1ps

module tsu_queue
    import tsu_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  req_t   push_req,
    input  logic   pop,
    output qstat_t qstat,
    output req_t   head
);

    req_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] fill_reg, fill_next;

    assign qstat.full       = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.head_valid = (fill_reg != '0);
    assign head             = entry_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + QCNT_W'(1);
        end
        else if (pop && !push) begin
            fill_next = fill_reg - QCNT_W'(1);
        end
    end

    // Hold the request payloads
    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            fill_reg <= fill_next;
        end
    end

endmodule

[hw/rtl/tsu_back.sv]
// Result sequencer: expands the request at the queue head into one result per
// cycle while not stalled, held in the output register. Depends on tsu_pkg.
`timescale 1ns / 1ps

module tsu_back
    import tsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  qstat_t      qstat,
    input  req_t        head,
    output logic        pop,
    input  logic        out_stall,
    output logic        out_valid,
    output logic [1:0]  out_kind,
    output logic [7:0]  out_byte,
    output logic [2:0]  reject_code,
    output logic [15:0] consumed_count,
    output logic        last_of_run
);

    logic        valid_reg, valid_next;
    logic [1:0]  idx_reg, idx_next;
    kind_t       kind_reg;
    logic [7:0]  byte_reg;
    err_t        err_reg;
    logic [15:0] count_reg;
    logic        last_reg;

    logic        load;
    logic        head_last;

    assign load      = qstat.head_valid && (!valid_reg || !out_stall);
    assign head_last = (head.kind != KIND_BYTE) || (idx_reg == head.last_idx);
    assign pop       = load && head_last;

    always_comb
    begin
        valid_next = valid_reg && out_stall;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = head_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    // Load the next result when the output register is free
    always_ff @(posedge clk)
    begin
        if (load) begin
            kind_reg  <= head.kind;
            byte_reg  <= (head.kind == KIND_BYTE) ? head.data[idx_reg] : 8'h00;
            err_reg   <= head.err;
            count_reg <= head.count;
            last_reg  <= head_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    assign out_valid      = valid_reg;
    assign out_kind       = kind_reg;
    assign out_byte       = byte_reg;
    assign reject_code    = err_reg;
    assign consumed_count = count_reg;
    assign last_of_run    = last_reg;

endmodule

[hw/rtl/toml_string_unescape_utf8.sv]
// TOML quoted-string unescaper with UTF-8 output.
// Input channel: one raw text byte per request (in_byte, first_byte, end_of_text) on
// in_valid / in_stall. Mark the opening quote with first_byte and the last byte of
// the available text with end_of_text.
// Output channel: one result per request on out_valid / out_stall: a decoded byte,
// a done with consumed_count, or a reject with reject_code. last_of_run marks the
// final result of an input byte. Discard decoded bytes of a string that ends in
// a reject.
// Each accepted byte's request is registered in the queue, then in the output register.
// Throughput: one input byte per cycle for plain text while in_stall is low; a
// unicode escape expands into up to four results, one per cycle from the output
// register while out_stall is low. The parser keeps taking bytes while the
// four-entry request queue has room; once it is full, in_stall rises.
// Reset clears the parse state, the queue and the output valid flag; in_stall is low
// during reset and a byte can be taken once reset is released. When the
// receiver stalls, the output holds its result and the queue absorbs up to four
// more requests before in_stall rises.
// Depends on tsu_pkg, tsu_front, tsu_queue and tsu_back.
`timescale 1ns / 1ps

module toml_string_unescape_utf8
    import tsu_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        first_byte,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  out_kind,
    output logic [7:0]  out_byte,
    output logic [2:0]  reject_code,
    output logic [15:0] consumed_count,
    output logic        last_of_run
);

    qstat_t qstat;
    logic   push;
    logic   pop;
    req_t   push_req;
    req_t   head;

    assign in_stall = qstat.full;

    tsu_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_byte     (in_byte),
        .first_byte  (first_byte),
        .end_of_text (end_of_text),
        .qstat       (qstat),
        .push        (push),
        .req         (push_req)
    );

    tsu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .pop      (pop),
        .qstat    (qstat),
        .head     (head)
    );

    tsu_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .qstat          (qstat),
        .head           (head),
        .pop            (pop),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .out_kind       (out_kind),
        .out_byte       (out_byte),
        .reject_code    (reject_code),
        .consumed_count (consumed_count),
        .last_of_run    (last_of_run)
    );

    // A done or a reject always closes the run of its input byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind != KIND_BYTE) |-> last_of_run)
    else $error("done or reject result without last_of_run");

    // Error code is set exactly on rejects
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_kind == KIND_REJECT) == (reject_code != ERR_NONE)))
    else $error("error code does not match result kind");

    // The queue never takes a request while full
    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && qstat.full))
    else $error("request pushed into a full queue");

    // Nothing is popped from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> qstat.head_valid)
    else $error("request popped from an empty queue");

endmodule

[tb/sv/testbench.sv]
// Self-checking bench for the TOML string unescaper: drives raw text bytes, predicts
// the decoded bytes, done counts and rejects, and checks every result in order.
// Depends on tsu_pkg and toml_string_unescape_utf8.
`timescale 1ns / 1ps

module testbench;
    import tsu_pkg::*;

    localparam int          COUNT_W        = 16;
    localparam int unsigned COUNT_MAX      = (32'd1 << COUNT_W) - 1;
    localparam int          RANDOM_ITEMS   = 210;
    localparam int          CHUNK_ITEMS    = 45;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          TAIL_CYCLES    = 16;

    // Characters that follow a backslash
    localparam logic [7:0] LETTER_B  = "b";
    localparam logic [7:0] LETTER_T  = "t";
    localparam logic [7:0] LETTER_N  = "n";
    localparam logic [7:0] LETTER_F  = "f";
    localparam logic [7:0] LETTER_R  = "r";
    localparam logic [7:0] LETTER_U4 = "u";
    localparam logic [7:0] LETTER_U8 = "U";

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       eot;
    } text_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        err_t        err;
        logic [15:0] count;
        logic        last;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = 8'h00;
    logic        first_byte = 1'b0;
    logic        end_of_text = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic [2:0]  reject_code;
    logic [15:0] consumed_count;
    logic        last_of_run;

    // Predicted parser state
    mode_t       parse_state = MODE_IDLE;
    logic        lit_str = 1'b0;
    int unsigned digits_left = 0;
    logic [31:0] cp_acc = '0;
    int unsigned consumed = 0;

    text_item_t  pending_text[$];
    logic [7:0]  text_bytes[$];
    result_t     decoded_run[$];
    result_t     expected_results[$];
    text_item_t  cur_item;
    result_t     got;
    result_t     want;

    bit          idle_on = 1'b1;
    bit          in_busy = 1'b0;
    int          send_gap = 0;
    int          stall_left = 0;
    int          stuck_cycles = 0;
    int          string_bytes = 0;
    int          items_sent = 0;
    int          results_checked = 0;
    int          done_seen = 0;
    int          reject_seen = 0;
    int          fail_count = 0;

    toml_string_unescape_utf8 #(
        .COUNT_WIDTH(COUNT_W)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .first_byte     (first_byte),
        .end_of_text    (end_of_text),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_kind       (out_kind),
        .out_byte       (out_byte),
        .reject_code    (reject_code),
        .consumed_count (consumed_count),
        .last_of_run    (last_of_run)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("mismatch %0d: %s", fail_count, msg);
        end
    endtask

    // ---------------------------------------------------------------
    // Decoder prediction
    // ---------------------------------------------------------------

    task automatic add_result(input kind_t k, input logic [7:0] d, input err_t e,
                              input logic [15:0] n);
        result_t r;
        r.kind  = k;
        r.data  = d;
        r.err   = e;
        r.count = n;
        r.last  = 1'b0;
        decoded_run = {decoded_run, r};
    endtask

    // Drop what this byte produced so far and report the error alone
    task automatic reject_string(input err_t e);
        decoded_run.delete();
        add_result(KIND_REJECT, 8'h00, e, 16'h0000);
        parse_state = MODE_IDLE;
    endtask

    task automatic predict_byte(input logic [7:0] c, input logic first, input logic eot);
        logic [7:0] close_ch;
        int         hexval;
        decoded_run.delete();
        if (first)
        begin
            // Open a new string, abandoning any in progress
            if (c == CH_QUOTE || c == CH_APOS)
            begin
                lit_str     = (c == CH_APOS);
                parse_state = MODE_BODY;
                digits_left = 0;
                cp_acc      = '0;
                consumed    = 1;
            end
            else
            begin
                reject_string(ERR_NO_QUOTE);
            end
        end
        else if (parse_state != MODE_IDLE)
        begin
            if (consumed < COUNT_MAX)
            begin
                consumed++;
            end
            close_ch = lit_str ? CH_APOS : CH_QUOTE;
            case (parse_state)
                MODE_BODY:
                begin
                    if (c == close_ch)
                    begin
                        add_result(KIND_DONE, 8'h00, ERR_NONE, consumed[15:0]);
                        parse_state = MODE_IDLE;
                    end
                    else if (lit_str || c != CH_BSL)
                    begin
                        add_result(KIND_BYTE, c, ERR_NONE, 16'h0000);
                    end
                    else
                    begin
                        parse_state = MODE_ESC;
                    end
                end
                MODE_ESC:
                begin
                    parse_state = MODE_BODY;
                    case (c)
                        CH_QUOTE:  add_result(KIND_BYTE, CH_QUOTE, ERR_NONE, 16'h0000);
                        CH_BSL:    add_result(KIND_BYTE, CH_BSL, ERR_NONE, 16'h0000);
                        LETTER_B:  add_result(KIND_BYTE, 8'h08, ERR_NONE, 16'h0000);
                        LETTER_T:  add_result(KIND_BYTE, 8'h09, ERR_NONE, 16'h0000);
                        LETTER_N:  add_result(KIND_BYTE, 8'h0a, ERR_NONE, 16'h0000);
                        LETTER_F:  add_result(KIND_BYTE, 8'h0c, ERR_NONE, 16'h0000);
                        LETTER_R:  add_result(KIND_BYTE, 8'h0d, ERR_NONE, 16'h0000);
                        LETTER_U4, LETTER_U8:
                        begin
                            digits_left = (c == LETTER_U4) ? 4 : 8;
                            cp_acc      = '0;
                            parse_state = MODE_HEX;
                        end
                        default:   reject_string(ERR_BAD_ESC);
                    endcase
                end
                default:
                begin
                    // Accumulate one hex digit of a unicode escape
                    if (c >= 8'h30 && c <= 8'h39)
                    begin
                        hexval = c - 8'h30;
                    end
                    else if (c >= 8'h61 && c <= 8'h66)
                    begin
                        hexval = c - 8'h61 + 10;
                    end
                    else if (c >= 8'h41 && c <= 8'h46)
                    begin
                        hexval = c - 8'h41 + 10;
                    end
                    else
                    begin
                        hexval = -1;
                    end
                    if (hexval < 0)
                    begin
                        reject_string(ERR_BAD_HEX);
                    end
                    else
                    begin
                        cp_acc = {cp_acc[27:0], hexval[3:0]};
                        if (digits_left > 0)
                        begin
                            digits_left--;
                        end
                        if (digits_left == 0)
                        begin
                            if (cp_acc > CP_MAX || (cp_acc >= SURR_LO && cp_acc <= SURR_HI))
                            begin
                                reject_string(ERR_BAD_CP);
                            end
                            else
                            begin
                                // Encode the code point as UTF-8
                                if (cp_acc <= 32'h7f)
                                begin
                                    add_result(KIND_BYTE, cp_acc[7:0], ERR_NONE, 16'h0000);
                                end
                                else if (cp_acc <= 32'h7ff)
                                begin
                                    add_result(KIND_BYTE, 8'hc0 | cp_acc[10:6], ERR_NONE, 16'h0);
                                    add_result(KIND_BYTE, 8'h80 | cp_acc[5:0], ERR_NONE, 16'h0);
                                end
                                else if (cp_acc <= 32'hffff)
                                begin
                                    add_result(KIND_BYTE, 8'he0 | cp_acc[15:12], ERR_NONE, 16'h0);
                                    add_result(KIND_BYTE, 8'h80 | cp_acc[11:6], ERR_NONE, 16'h0);
                                    add_result(KIND_BYTE, 8'h80 | cp_acc[5:0], ERR_NONE, 16'h0);
                                end
                                else
                                begin
                                    add_result(KIND_BYTE, 8'hf0 | cp_acc[20:18], ERR_NONE, 16'h0);
                                    add_result(KIND_BYTE, 8'h80 | cp_acc[17:12], ERR_NONE, 16'h0);
                                    add_result(KIND_BYTE, 8'h80 | cp_acc[11:6], ERR_NONE, 16'h0);
                                    add_result(KIND_BYTE, 8'h80 | cp_acc[5:0], ERR_NONE, 16'h0);
                                end
                                parse_state = MODE_BODY;
                            end
                        end
                    end
                end
            endcase
        end

        // Text that ends with the string still open
        if (eot && parse_state != MODE_IDLE)
        begin
            reject_string(ERR_UNTERM);
        end

        if (decoded_run.size() != 0)
        begin
            decoded_run[decoded_run.size() - 1].last = 1'b1;
        end
        foreach (decoded_run[i])
        begin
            expected_results = {expected_results, decoded_run[i]};
        end
    endtask

    // ---------------------------------------------------------------
    // Stimulus builders
    // ---------------------------------------------------------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 24);
    endfunction

    task automatic push_item(input logic [7:0] d, input logic first, input logic eot);
        text_item_t t;
        t.data  = d;
        t.first = first;
        t.eot   = eot;
        pending_text = {pending_text, t};
        string_bytes++;
    endtask

    // Queue the built text, first byte flagged, optionally the last as end of text
    task automatic send_text(input bit eot_last);
        foreach (text_bytes[i])
        begin
            push_item(text_bytes[i], i == 0, eot_last && (i == text_bytes.size() - 1));
        end
        text_bytes.delete();
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 10)
        begin
            return 8'h30 + nib;
        end
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + nib - 8'd10;
    endfunction

    task automatic push_hex(input logic [31:0] cp, input int nd);
        for (int i = nd - 1; i >= 0; i--)
        begin
            text_bytes = {text_bytes, hex_char(cp[4 * i +: 4])};
        end
    endtask

    function automatic logic [31:0] random_cp(input int top_class);
        logic [31:0] cp;
        case ($urandom_range(0, top_class))
            0:       cp = $urandom_range(0, 32'h7f);
            1:       cp = $urandom_range(32'h80, 32'h7ff);
            2:
            begin
                do
                    cp = $urandom_range(32'h800, 32'hffff);
                while (cp >= SURR_LO && cp <= SURR_HI);
            end
            default: cp = $urandom_range(32'h10000, CP_MAX);
        endcase
        return cp;
    endfunction

    // Build a well-formed string into text_bytes, with or without its closing quote
    task automatic build_string(input bit lit, input bit closed);
        int         nseg;
        logic [7:0] b;
        text_bytes.delete();
        b = lit ? CH_APOS : CH_QUOTE;
        text_bytes = {text_bytes, b};
        nseg = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 8);
        for (int s = 0; s < nseg; s++)
        begin
            if (lit)
            begin
                do
                    b = $urandom_range(0, 255);
                while (b == CH_APOS);
                text_bytes = {text_bytes, b};
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4:
                    begin
                        do
                            b = $urandom_range(0, 255);
                        while (b == CH_QUOTE || b == CH_BSL);
                        text_bytes = {text_bytes, b};
                    end
                    5, 6:
                    begin
                        text_bytes = {text_bytes, CH_BSL};
                        case ($urandom_range(0, 6))
                            0:       text_bytes = {text_bytes, CH_QUOTE};
                            1:       text_bytes = {text_bytes, CH_BSL};
                            2:       text_bytes = {text_bytes, LETTER_B};
                            3:       text_bytes = {text_bytes, LETTER_T};
                            4:       text_bytes = {text_bytes, LETTER_N};
                            5:       text_bytes = {text_bytes, LETTER_F};
                            default: text_bytes = {text_bytes, LETTER_R};
                        endcase
                    end
                    7:
                    begin
                        text_bytes = {text_bytes, CH_BSL, LETTER_U4};
                        push_hex(random_cp(2), 4);
                    end
                    default:
                    begin
                        text_bytes = {text_bytes, CH_BSL, LETTER_U8};
                        push_hex(random_cp(3), 8);
                    end
                endcase
            end
        end
        if (closed)
        begin
            b = lit ? CH_APOS : CH_QUOTE;
            text_bytes = {text_bytes, b};
        end
    endtask

    // One malformed sequence: each rejection kind, content errors sometimes on the last byte
    task automatic push_broken();
        logic [7:0] b;
        int         cut;
        bit         wide;
        case ($urandom_range(0, 5))
            0:
            begin
                // cut the text short before the closing quote
                build_string($urandom_range(0, 1), 1'b1);
                cut = $urandom_range(1, text_bytes.size() - 1);
                while (text_bytes.size() > cut)
                begin
                    text_bytes.delete(text_bytes.size() - 1);
                end
                send_text(1'b1);
            end
            1:
            begin
                build_string(1'b0, 1'b0);
                text_bytes = {text_bytes, CH_BSL};
                do
                    b = $urandom_range(0, 255);
                while (b inside {CH_QUOTE, CH_BSL, LETTER_B, LETTER_T, LETTER_N, LETTER_F,
                                 LETTER_R, LETTER_U4, LETTER_U8});
                text_bytes = {text_bytes, b};
                send_text($urandom_range(0, 2) == 0);
            end
            2:
            begin
                build_string(1'b0, 1'b0);
                wide = $urandom_range(0, 1);
                b = wide ? LETTER_U8 : LETTER_U4;
                text_bytes = {text_bytes, CH_BSL, b};
                push_hex($urandom, $urandom_range(0, wide ? 7 : 3));
                do
                    b = $urandom_range(0, 255);
                while (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
                text_bytes = {text_bytes, b};
                send_text($urandom_range(0, 2) == 0);
            end
            3:
            begin
                build_string(1'b0, 1'b0);
                text_bytes = {text_bytes, CH_BSL};
                if ($urandom_range(0, 1))
                begin
                    text_bytes = {text_bytes, LETTER_U4};
                    push_hex($urandom_range(SURR_LO, SURR_HI), 4);
                end
                else
                begin
                    text_bytes = {text_bytes, LETTER_U8};
                    push_hex($urandom_range(CP_MAX + 1, 32'hffff_ffff), 8);
                end
                send_text($urandom_range(0, 2) == 0);
            end
            4:
            begin
                // restart in the middle of an open string
                build_string($urandom_range(0, 1), 1'b0);
                send_text(1'b0);
                build_string($urandom_range(0, 1), 1'b1);
                send_text(1'b0);
            end
            default:
            begin
                do
                    b = $urandom_range(0, 255);
                while (b == CH_QUOTE || b == CH_APOS);
                push_item(b, 1'b1, $urandom_range(0, 1));
            end
        endcase
    endtask

    task automatic push_random_sequence();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            build_string($urandom_range(0, 1), 1'b1);
            send_text($urandom_range(0, 3) == 0);
        end
        else if (r < 90)
        begin
            push_broken();
        end
        else
        begin
            // loose bytes, mostly ignored while idle
            repeat ($urandom_range(1, 3))
            begin
                push_item($urandom_range(0, 255), $urandom_range(0, 4) == 0,
                          $urandom_range(0, 3) == 0);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_text.size() != 0 || in_busy || expected_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // ---------------------------------------------------------------
    // Request driver and receiver stalls, both on the falling edge
    // ---------------------------------------------------------------

    always @(negedge clk)
    begin
        if (rst_n && !in_busy)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_text.size() != 0)
            begin
                cur_item = pending_text.pop_front();
                in_byte     <= cur_item.data;
                first_byte  <= cur_item.first;
                end_of_text <= cur_item.eot;
                in_valid    <= 1'b1;
                in_busy     = 1'b1;
                send_gap    = pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = pick_gap();
                out_stall <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: check results, then predict from the accepted request
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = {out_kind, out_byte, reject_code, consumed_count, last_of_run};
                if (expected_results.size() == 0)
                begin
                    note_failure($sformatf(
                        "unexpected result kind %0d byte %02h err %0d count %0d last %0b",
                        got.kind, got.data, got.err, got.count, got.last));
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (want.kind == KIND_DONE)
                    begin
                        done_seen++;
                    end
                    if (want.kind == KIND_REJECT)
                    begin
                        reject_seen++;
                    end
                    if (got !== want)
                    begin
                        note_failure($sformatf({"expected kind %0d byte %02h err %0d count %0d ",
                            "last %0b, got kind %0d byte %02h err %0d count %0d last %0b"},
                            want.kind, want.data, want.err, want.count, want.last,
                            got.kind, got.data, got.err, got.count, got.last));
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_byte(in_byte, first_byte, end_of_text);
                in_busy = 1'b0;
                items_sent++;
            end
        end
    end

    // Abort when no request moves on either side for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            stuck_cycles = 0;
        end
        else
        begin
            stuck_cycles++;
        end
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------

    initial
    begin
        int chunk;
        int target;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // literal string: byte extremes and a backslash kept as text
        push_item(CH_APOS, 1'b1, 1'b0);
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'hff, 1'b0, 1'b0);
        push_item(CH_BSL, 1'b0, 1'b0);
        push_item(CH_APOS, 1'b0, 1'b0);
        // highest code point with mixed-case digits, then a restart
        push_item(CH_QUOTE, 1'b1, 1'b0);
        push_item(CH_BSL, 1'b0, 1'b0);
        push_item(LETTER_U8, 1'b0, 1'b0);
        push_item("0", 1'b0, 1'b0);
        push_item("0", 1'b0, 1'b0);
        push_item("1", 1'b0, 1'b0);
        push_item("0", 1'b0, 1'b0);
        push_item("f", 1'b0, 1'b0);
        push_item("F", 1'b0, 1'b0);
        push_item("f", 1'b0, 1'b0);
        push_item("F", 1'b0, 1'b0);
        // restart, then an unknown escape
        push_item(CH_QUOTE, 1'b1, 1'b0);
        push_item(CH_BSL, 1'b0, 1'b0);
        push_item("z", 1'b0, 1'b0);
        // missing opening quote, then a byte ignored while idle
        push_item("x", 1'b1, 1'b0);
        push_item(CH_QUOTE, 1'b0, 1'b0);
        // bad hex digit
        push_item(CH_QUOTE, 1'b1, 1'b0);
        push_item(CH_BSL, 1'b0, 1'b0);
        push_item(LETTER_U4, 1'b0, 1'b0);
        push_item("g", 1'b0, 1'b0);
        // text ends inside the string
        push_item(CH_APOS, 1'b1, 1'b0);
        push_item("a", 1'b0, 1'b1);
        wait_drained();

        // random sequences in chunks; every third chunk runs without idling
        chunk = 0;
        while (string_bytes < RANDOM_ITEMS)
        begin
            idle_on = (chunk % 3 != 2);
            target  = string_bytes + CHUNK_ITEMS;
            while (string_bytes < target && string_bytes < RANDOM_ITEMS)
            begin
                push_random_sequence();
            end
            wait_drained();
            chunk++;
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            note_failure($sformatf("%0d expected results never arrived",
                                   expected_results.size()));
        end

        $display("Covered %0d text bytes, %0d results checked (%0d strings closed, %0d rejected),",
                 items_sent, results_checked, done_seen, reject_seen);
        $display("with random idle gaps and receiver stalls; %0d mismatches.", fail_count);
        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
